[rtl/salc_pkg.sv]
// salc_pkg: shared constants, codes and control structs of the lru cache model
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  // default sizing of the cache
  localparam int DEF_MAX_SETS   = 256;
  localparam int DEF_MAX_WAYS   = 8;
  localparam int DEF_ADDR_WIDTH = 32;

  // field widths fixed by the interface
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 32;
  localparam int OUTCOME_W = 2;
  localparam int OFF_W     = 5;
  localparam int IDX_W     = 4;
  localparam int WAYS_W    = 4;
  localparam int SHIFT_W   = 6;
  localparam int IDXRAW_W  = 16;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register map, indexed by word address
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  // register reset values
  localparam logic [OFF_W-1:0]  RST_OFFSET_BITS = 5'd5;
  localparam logic [IDX_W-1:0]  RST_INDEX_BITS  = 4'd8;
  localparam logic [WAYS_W-1:0] RST_WAYS        = 4'd4;

  // access outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic clear;
  } salc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slot_free;
  } salc_sts_t;

endpackage

`default_nettype wire

[rtl/salc_ram.sv]
// salc_ram: generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                                      clk,
  input  wire                                      we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                         wdata,
  input  wire                                      re,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its word while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/salc_ctrl.sv]
// salc_ctrl: sequencer for clearing pass, lookup and set update
`timescale 1ns / 1ps
`default_nettype none

module salc_ctrl
  import salc_pkg::*;
#(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  salc_sts_t        sts,
  output salc_cmd_t        cmd,
  output logic [SET_W-1:0] clr_addr
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_t;

  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  state_t           state_r;
  logic             in_ready_r;
  logic [SET_W-1:0] clr_cnt_r;

  // commands decoded from state and handshake
  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.update = (state_r == S_UPDATE) && sts.slot_free;
    cmd.clear  = (state_r == S_CLEAR);
  end

  assign in_ready = in_ready_r;
  assign clr_addr = clr_cnt_r;

  // state, ready and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_SET) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_UPDATE;
            in_ready_r <= 1'b0;
          end
        end
        S_UPDATE: begin
          if (sts.slot_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_CLEAR;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an accepted word is always followed by its update state
  a_accept_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_UPDATE))
    else $error("accept not followed by update state");

  // clearing never overlaps a lookup or an update
  a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!cmd.accept && !cmd.update && !in_ready))
    else $error("clearing pass overlaps an access");
`endif

endmodule

`default_nettype wire

[rtl/salc_dp.sv]
// salc_dp: address split, set row lookup, lru reorder, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module salc_dp
  import salc_pkg::*;
#(
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int MAX_WAYS   = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
  parameter int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int WAY_CW     = $clog2(MAX_WAYS + 1)
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [OFF_W-1:0]       offset_bits,
  input  wire  [IDX_W-1:0]       index_bits,
  input  wire  [WAY_CW-1:0]      nways,
  input  wire  [ADDR_WIDTH-1:0]  in_address,
  input  salc_cmd_t              cmd,
  input  wire  [SET_W-1:0]       clr_addr,
  output salc_sts_t              sts,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [OUTCOME_W-1:0]   out_outcome,
  output logic [TAG_W-1:0]       out_evicted_tag,
  output logic [CNT_W-1:0]       out_hit_total,
  output logic [CNT_W-1:0]       out_access_total
);

  localparam int XW    = (ADDR_WIDTH > TAG_W) ? ADDR_WIDTH : TAG_W;
  localparam int ROW_W = WAY_CW + MAX_WAYS * TAG_W;
  localparam logic [IDXRAW_W-1:0] SET_MASK = IDXRAW_W'(MAX_SETS - 1);

  // set count that is not a power of two: reciprocal multiply for the wrap
  localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
  localparam int RCP_W     = IDXRAW_W + 2;
  localparam int RCP_SH    = IDXRAW_W + SET_W;
  localparam int PROD_W    = IDXRAW_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

  // address split
  logic [XW-1:0]       addr_ext;
  logic [SHIFT_W-1:0]  tag_sh;
  logic [XW-1:0]       tag_shifted;
  logic [XW-1:0]       idx_shifted;
  logic [IDXRAW_W-1:0] idx_mask;
  logic [IDXRAW_W-1:0] idx_raw;
  logic [PROD_W-1:0]   idx_prod;
  logic [IDXRAW_W-1:0] idx_quo;
  logic [IDXRAW_W-1:0] idx_mod;
  logic [SET_W-1:0]    set_in;

  // captured access
  logic [TAG_W-1:0]    tag_r;
  logic [SET_W-1:0]    set_r;

  // set row
  logic [ROW_W-1:0]    row_q;
  logic [ROW_W-1:0]    row_new;
  logic [WAY_CW-1:0]   cnt;
  logic [TAG_W-1:0]    tags     [MAX_WAYS];
  logic [TAG_W-1:0]    tags_up  [MAX_WAYS];
  logic [MAX_WAYS-1:0] hit_vec;
  logic                found;
  logic                full;
  logic [WAY_CW-1:0]   eff;
  logic [WAY_CW-1:0]   hit_way;
  logic [WAY_CW-1:0]   rm_pos;
  logic [WAY_CW-1:0]   ins_pos;
  logic [WAY_CW-1:0]   cnt_new;
  logic [OUTCOME_W-1:0] outcome;
  logic [TAG_W-1:0]    evicted;

  // counters and result register
  logic [CNT_W-1:0]     hit_cnt_r;
  logic [CNT_W-1:0]     acc_cnt_r;
  logic [CNT_W-1:0]     hit_cnt_nxt;
  logic [CNT_W-1:0]     acc_cnt_nxt;
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] out_outcome_r;
  logic [TAG_W-1:0]     out_evicted_r;
  logic [CNT_W-1:0]     out_hit_r;
  logic [CNT_W-1:0]     out_acc_r;

  // ram port signals
  logic                ram_we;
  logic [SET_W-1:0]    ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;

  // offset, index and tag from the incoming word
  always_comb begin
    addr_ext    = XW'(in_address);
    tag_sh      = SHIFT_W'(offset_bits) + SHIFT_W'(index_bits);
    tag_shifted = addr_ext >> tag_sh;
    idx_shifted = addr_ext >> offset_bits;
    idx_mask    = IDXRAW_W'((17'd1 << index_bits) - 17'd1);
    idx_raw     = IDXRAW_W'(idx_shifted) & idx_mask;
    idx_prod    = PROD_W'(idx_raw) * PROD_W'(RCP);
    idx_quo     = IDXRAW_W'(idx_prod >> RCP_SH);
    idx_mod     = idx_raw - IDXRAW_W'(idx_quo * IDXRAW_W'(MAX_SETS));
    set_in      = SETS_POW2 ? SET_W'(idx_raw & SET_MASK) : SET_W'(idx_mod);
  end

  // capture tag and set on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_r <= tag_shifted[TAG_W-1:0];
      set_r <= set_in;
    end
  end

  // one row per set: fill count on top, tags in recency order below
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (row_q)
  );

  // compare, pick positions and rebuild the row
  always_comb begin
    cnt = row_q[ROW_W-1 -: WAY_CW];
    for (int j = 0; j < MAX_WAYS; j++) begin
      tags[j] = row_q[j*TAG_W +: TAG_W];
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (j + 1 < MAX_WAYS) begin
        tags_up[j] = tags[j+1];
      end else begin
        tags_up[j] = tags[j];
      end
    end

    eff  = (cnt < nways) ? cnt : nways;
    full = (cnt >= nways);

    for (int j = 0; j < MAX_WAYS; j++) begin
      hit_vec[j] = (WAY_CW'(j) < eff) && (tags[j] == tag_r);
    end
    found   = |hit_vec;
    hit_way = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_way = WAY_CW'(j);
      end
    end

    // hit: lift the way to the top of the valid part
    // fill: place at the first empty way
    // evict: drop the least recent and place at the top of the active ways
    if (found) begin
      rm_pos  = hit_way;
      ins_pos = eff - 1'b1;
      cnt_new = cnt;
      outcome = OUT_HIT;
      evicted = '0;
    end else if (!full) begin
      rm_pos  = cnt;
      ins_pos = cnt;
      cnt_new = cnt + 1'b1;
      outcome = OUT_FILL;
      evicted = '0;
    end else begin
      rm_pos  = '0;
      ins_pos = nways - 1'b1;
      cnt_new = cnt;
      outcome = OUT_EVICT;
      evicted = tags[0];
    end

    row_new = '0;
    row_new[ROW_W-1 -: WAY_CW] = cnt_new;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (WAY_CW'(j) < rm_pos) begin
        row_new[j*TAG_W +: TAG_W] = tags[j];
      end else if (WAY_CW'(j) < ins_pos) begin
        row_new[j*TAG_W +: TAG_W] = tags_up[j];
      end else if (WAY_CW'(j) == ins_pos) begin
        row_new[j*TAG_W +: TAG_W] = tag_r;
      end else begin
        row_new[j*TAG_W +: TAG_W] = tags[j];
      end
    end

    hit_cnt_nxt = hit_cnt_r + CNT_W'(found);
    acc_cnt_nxt = acc_cnt_r + 1'b1;
  end

  // write back the updated row, or a zero count during clearing
  always_comb begin
    ram_we    = cmd.update || cmd.clear;
    ram_waddr = cmd.clear ? clr_addr : set_r;
    ram_wdata = cmd.clear ? '0 : row_new;
  end

  // hit and access counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r <= '0;
      acc_cnt_r <= '0;
    end else if (cmd.update) begin
      hit_cnt_r <= hit_cnt_nxt;
      acc_cnt_r <= acc_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_outcome_r <= outcome;
      out_evicted_r <= evicted;
      out_hit_r     <= hit_cnt_nxt;
      out_acc_r     <= acc_cnt_nxt;
    end
  end

  assign sts.slot_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_evicted_tag  = out_evicted_r;
  assign out_hit_total    = out_hit_r;
  assign out_access_total = out_acc_r;

`ifndef SYNTHESIS
  // a row update always leaves a result word for the output side
  a_update_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update without result word");

  // the fill count written back never exceeds the way count
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (cnt_new <= WAY_CW'(MAX_WAYS)))
    else $error("fill count beyond way count");
`endif

endmodule

`default_nettype wire

[rtl/set_assoc_lru_cache_model.sv]
// set_assoc_lru_cache_model: top level with configuration registers and apb port
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+-----------------------------
//   in      | in_valid, in_ready, in_address | sink      | one access address
//   out     | out_valid, out_ready, out_*    | source    | outcome, evicted tag, totals
//   cfg     | psel, penable, pwrite, paddr.. | apb slave | offset_bits, index_bits, ways
//
// each access: accept with the set row read, then one read-modify-write
// of that row in the single write port row ram.
// after reset a clearing pass writes every set row with in_ready low; configuration
// writes are taken throughout.
// a new word is accepted while the previous result still waits in the output register;
// the update cycle waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_model
  import salc_pkg::*;
#(
  parameter int MAX_SETS   = DEF_MAX_SETS,
  parameter int MAX_WAYS   = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [ADDR_WIDTH-1:0] in_address,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [OUTCOME_W-1:0]  out_outcome,
  output logic [TAG_W-1:0]      out_evicted_tag,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_access_total,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [CFG_AW-1:0]     paddr,
  input  wire  [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_CW = $clog2(MAX_WAYS + 1);

  logic [OFF_W-1:0]  offset_bits_r;
  logic [IDX_W-1:0]  index_bits_r;
  logic [WAYS_W-1:0] ways_r;
  logic [WAY_CW-1:0] nways;
  logic              cfg_wr;
  salc_cmd_t         cmd;
  salc_sts_t         sts;
  logic [SET_W-1:0]  clr_addr;

  // apb register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= RST_OFFSET_BITS;
      index_bits_r  <= RST_INDEX_BITS;
      ways_r        <= RST_WAYS;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_OFFSET_BITS: offset_bits_r <= pwdata[OFF_W-1:0];
        REG_INDEX_BITS:  index_bits_r  <= pwdata[IDX_W-1:0];
        REG_WAYS:        ways_r        <= pwdata[WAYS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // apb register reads
  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_BITS: prdata = CFG_DW'(offset_bits_r);
      REG_INDEX_BITS:  prdata = CFG_DW'(index_bits_r);
      REG_WAYS:        prdata = CFG_DW'(ways_r);
      default:         prdata = '0;
    endcase
  end

  // associativity in use: zero means one, large values saturate
  always_comb begin
    if (ways_r == '0) begin
      nways = WAY_CW'(1);
    end else if (ways_r > WAYS_W'(MAX_WAYS)) begin
      nways = WAY_CW'(MAX_WAYS);
    end else begin
      nways = WAY_CW'(ways_r);
    end
  end

  salc_ctrl #(
    .MAX_SETS (MAX_SETS),
    .SET_W    (SET_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .clr_addr (clr_addr)
  );

  salc_dp #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .SET_W      (SET_W),
    .WAY_CW     (WAY_CW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .offset_bits      (offset_bits_r),
    .index_bits       (index_bits_r),
    .nways            (nways),
    .in_address       (in_address),
    .cmd              (cmd),
    .clr_addr         (clr_addr),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_evicted_tag  (out_evicted_tag),
    .out_hit_total    (out_hit_total),
    .out_access_total (out_access_total)
  );

`ifndef SYNTHESIS
  // only one access is in flight between accept and update
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second access accepted while one is in flight");
`endif

endmodule

`default_nettype wire

[test/set_assoc_lru_cache_model_tb.sv]
// set_assoc_lru_cache_model_tb: self-checking bench with access predictor, driver and monitor
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_tb;
  import salc_pkg::*;

  localparam int SETS = DEF_MAX_SETS;
  localparam int WAYS = DEF_MAX_WAYS;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int LONG_HOLD_AT = 700;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [TAG_W-1:0]     evicted_tag;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     access_total;
  } access_result_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [31:0]           in_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [OUTCOME_W-1:0]  out_outcome;
  logic [TAG_W-1:0]      out_evicted_tag;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_access_total;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_AW-1:0]     paddr = '0;
  logic [CFG_DW-1:0]     pwdata = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  set_assoc_lru_cache_model dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_evicted_tag  (out_evicted_tag),
    .out_hit_total    (out_hit_total),
    .out_access_total (out_access_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // shadow of the configuration registers
  logic [OFF_W-1:0]  cfg_off = RST_OFFSET_BITS;
  logic [IDX_W-1:0]  cfg_idx = RST_INDEX_BITS;
  logic [WAYS_W-1:0] cfg_ways = RST_WAYS;

  // predicted cache contents, ways in recency order, lru first
  logic [31:0] tag_mirror [0:SETS*WAYS-1];
  bit          valid_mirror [0:SETS*WAYS-1];
  logic [31:0] hit_count = '0;
  logic [31:0] access_count = '0;

  logic [31:0]    access_addrs [$];
  access_result_t predicted_results [$];

  int  words_queued = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  bit  calm = 1'b0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SETS*WAYS; i++) begin
      tag_mirror[i] = '0;
      valid_mirror[i] = 1'b0;
    end
  end

  // one access against the mirror: outcome, victim and running totals
  function automatic access_result_t lookup_access(input logic [31:0] addr);
    access_result_t r;
    logic [63:0]    wide;
    logic [63:0]    set_raw;
    logic [31:0]    tag;
    int unsigned    n, sh, base, w, last;
    bit             found;
    wide = {32'd0, addr};
    n = cfg_ways;
    if (n == 0) n = 1;
    if (n > WAYS) n = WAYS;
    sh = cfg_off + cfg_idx;
    set_raw = (wide >> cfg_off) & ((64'd1 << cfg_idx) - 64'd1);
    tag = 32'(wide >> sh);
    base = set_raw[7:0] * WAYS;
    r = '0;
    found = 1'b0;
    w = 0;
    while (w < n && !found) begin
      if (valid_mirror[base+w] && tag_mirror[base+w] == tag) found = 1'b1;
      else w++;
    end
    if (found) begin
      // slide the hit way up to the last valid position
      last = w;
      while (last + 1 < n && valid_mirror[base+last+1]) begin
        tag_mirror[base+last] = tag_mirror[base+last+1];
        last++;
      end
      tag_mirror[base+last] = tag;
      hit_count++;
      r.outcome = OUT_HIT;
    end else begin
      w = 0;
      while (w < n && valid_mirror[base+w]) w++;
      if (w < n) begin
        tag_mirror[base+w] = tag;
        valid_mirror[base+w] = 1'b1;
        r.outcome = OUT_FILL;
      end else begin
        // full set: drop the lru tag and shift the rest down
        r.evicted_tag = tag_mirror[base];
        for (int unsigned k = 1; k < n; k++) tag_mirror[base+k-1] = tag_mirror[base+k];
        tag_mirror[base+n-1] = tag;
        r.outcome = OUT_EVICT;
      end
    end
    access_count++;
    r.hit_total = hit_count;
    r.access_total = access_count;
    return r;
  endfunction

  // driver: offers queued words, predicts each on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_results.push_back(lookup_access(in_address));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (access_addrs.size() > 0) begin
          in_valid <= 1'b1;
          in_address <= access_addrs.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word, drives ready with gaps and one long hold
  always @(posedge clk) begin
    access_result_t seen;
    access_result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_outcome, out_evicted_tag, out_hit_total, out_access_total};
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: outcome %0d evicted %h hits %0d accesses %0d",
                   seen.outcome, seen.evicted_tag, seen.hit_total, seen.access_total);
      end else begin
        want = predicted_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: outcome %0d/%0d evicted %h/%h hits %0d/%0d accesses %0d/%0d",
                     results_seen, want.outcome, seen.outcome, want.evicted_tag,
                     seen.evicted_tag, want.hit_total, seen.hit_total,
                     want.access_total, seen.access_total);
        end
      end
      results_seen++;
    end
    if (!hold_done && results_seen == LONG_HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 17);
    end
  end

  // apb write: setup then access, shadow follows the register's masking
  task automatic reg_write(input logic [1:0] sel, input logic [31:0] value, input bit noisy);
    logic [31:0] data;
    data = value;
    if (noisy) data[31:8] = 24'($urandom);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_OFFSET_BITS: cfg_off = data[OFF_W-1:0];
      REG_INDEX_BITS:  cfg_idx = data[IDX_W-1:0];
      REG_WAYS:        cfg_ways = data[WAYS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int off_v, input int idx_v, input int ways_v);
    reg_write(REG_OFFSET_BITS, off_v, $urandom_range(0, 1) == 1);
    reg_write(REG_INDEX_BITS, idx_v, $urandom_range(0, 1) == 1);
    reg_write(REG_WAYS, ways_v, $urandom_range(0, 1) == 1);
  endtask

  task automatic push_addr(input logic [31:0] a);
    access_addrs.push_back(a);
    words_queued++;
  endtask

  // sender pause until every queued word has come back
  task automatic wait_drained();
    while (results_seen != words_queued) @(posedge clk);
  endtask

  // random accesses over a few sets and a small tag pool so hits and evictions mix
  task automatic queue_accesses(input int count);
    logic [31:0] tags [0:11];
    logic [31:0] sets [0:3];
    logic [63:0] a;
    int          sh, n, pool;
    sh = cfg_off + cfg_idx;
    n = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS) ? WAYS : cfg_ways;
    pool = n + $urandom_range(0, 4);
    for (int i = 0; i < 12; i++) tags[i] = $urandom;
    for (int i = 0; i < 4; i++) sets[i] = $urandom;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        a = {32'd0, $urandom};
      end else begin
        a = ({32'd0, tags[$urandom_range(0, pool-1)]} << sh)
          | (({32'd0, sets[$urandom_range(0, 3)]} & ((64'd1 << cfg_idx) - 64'd1)) << cfg_off)
          | ({32'd0, $urandom} & ((64'd1 << cfg_off) - 64'd1));
      end
      push_addr(a[31:0]);
    end
  endtask

  // run sequence
  initial begin
    int off_v, idx_v, ways_v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: fills, a hit in the lru way, then evictions in set 0
    push_addr(32'h0000_0000);
    push_addr(32'hFFFF_FFFF);
    push_addr(32'h0000_001F);
    push_addr(32'h0000_2000);
    push_addr(32'h0000_4000);
    push_addr(32'h0000_6000);
    push_addr(32'h0000_2010);
    push_addr(32'h0000_0000);
    push_addr(32'h0000_8000);
    push_addr(32'h0000_4000);
    wait_drained();

    // zero ways as one, offset and index past the address so the tag is zero
    set_geometry(31, 15, 0);
    push_addr(32'h1234_5678);
    push_addr(32'hFFFF_FFFF);
    push_addr(32'h8000_0000);
    push_addr(32'h0000_0000);
    wait_drained();

    // ways above the maximum saturate, whole address is the tag
    set_geometry(0, 0, 15);
    push_addr(32'hAAAA_AAAA);
    push_addr(32'h5555_5555);
    push_addr(32'hAAAA_AAAA);
    wait_drained();

    // three ways, index wider than the sets wraps, unmapped register ignored
    set_geometry(16, 15, 3);
    reg_write(REG_UNMAPPED, $urandom, 1'b0);
    push_addr(32'hFFFF_0000);
    push_addr(32'h7FFF_0000);
    push_addr(32'hFFFF_FFFF);
    push_addr(32'h00FF_0000);
    wait_drained();

    // random phases, extremes first, last one without idling
    for (int p = 0; p < 9; p++) begin
      if (p == 0) begin
        off_v = 16; idx_v = 8; ways_v = 8;
      end else if (p == 1) begin
        off_v = 0; idx_v = 0; ways_v = 1;
      end else begin
        off_v = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
        idx_v = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        ways_v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      end
      if (p == 8) calm = 1'b1;
      set_geometry(off_v, idx_v, ways_v);
      queue_accesses(180);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("set_assoc_lru_cache_model_tb: PASS");
    end else begin
      $display("set_assoc_lru_cache_model_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #7_200_000;
    $display("set_assoc_lru_cache_model_tb: FAIL");
    $finish;
  end

endmodule
